// ===== src/kab_pkg.sv =====
// Shared types, constants and the control store for the keyed amount buffer.
// Every other file of the block imports this package; it depends on nothing.
`default_nettype none

package kab_pkg;

   localparam int SLOTS     = 8;
   localparam int KEY_BITS  = 8;
   localparam int REQ_KEY_W = 8;
   localparam int REQ_AMT_W = 16;
   localparam int AMT_W     = 24;
   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SPAN_W    = IDX_W + 1;
   localparam int PC_W      = 3;

   localparam logic [AMT_W-1:0] AMT_MAX = '1;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_TAKE   = 2'd2,
      OP_COUNT  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_IGNORED = 3'd1,
      ST_FULL    = 3'd2,
      ST_ABSENT  = 3'd3,
      ST_SHORT   = 3'd4,
      ST_SAT     = 3'd5
   } status_type;

   // Datapath action selected by the current control word.
   typedef enum logic [4:0] {
      ACT_FETCH = 5'b00001,
      ACT_SCAN  = 5'b00010,
      ACT_EXEC  = 5'b00100,
      ACT_TRIM  = 5'b01000,
      ACT_EMIT  = 5'b10000
   } act_type;

   // Branch condition tested at the end of a step.
   typedef enum logic [4:0] {
      C_REQ_TAKEN   = 5'b00001,
      C_SCAN_LAST   = 5'b00010,
      C_TRIM_NEEDED = 5'b00100,
      C_TRIM_MORE   = 5'b01000,
      C_OUT_FREE    = 5'b10000
   } cond_type;

   localparam logic [PC_W-1:0] PC_FETCH = 3'd0;
   localparam logic [PC_W-1:0] PC_SCAN  = 3'd1;
   localparam logic [PC_W-1:0] PC_EXEC  = 3'd2;
   localparam logic [PC_W-1:0] PC_TRIM  = 3'd3;
   localparam logic [PC_W-1:0] PC_EMIT  = 3'd4;

   typedef struct packed {
      act_type          act;
      cond_type         cond;
      logic [PC_W-1:0]  tgt_true;
      logic [PC_W-1:0]  tgt_false;
   } uword_type;

   // Condition flags reported by the datapath to the sequencer.
   typedef struct packed {
      logic req_taken;
      logic scan_last;
      logic trim_needed;
      logic trim_more;
      logic out_free;
   } dp_flags_type;

   // Control store: one word per step, next step chosen by the condition.
   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      unique case (pc)
         PC_FETCH: w = '{ACT_FETCH, C_REQ_TAKEN,   PC_SCAN,  PC_FETCH};
         PC_SCAN:  w = '{ACT_SCAN,  C_SCAN_LAST,   PC_EXEC,  PC_SCAN};
         PC_EXEC:  w = '{ACT_EXEC,  C_TRIM_NEEDED, PC_TRIM,  PC_EMIT};
         PC_TRIM:  w = '{ACT_TRIM,  C_TRIM_MORE,   PC_TRIM,  PC_EMIT};
         PC_EMIT:  w = '{ACT_EMIT,  C_OUT_FREE,    PC_FETCH, PC_EMIT};
         default:  w = '{ACT_FETCH, C_REQ_TAKEN,   PC_SCAN,  PC_FETCH};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== src/kab_req_if.sv =====
// Request channel of the keyed amount buffer: handshake plus one command.
// Depends on kab_pkg for the field types and widths.
`default_nettype none

interface kab_req_if import kab_pkg::*;;
   logic                 valid;
   logic                 ready;
   op_type               op;
   logic [REQ_KEY_W-1:0] resource_key;
   logic [REQ_AMT_W-1:0] amount;

   modport source (output valid, output op, output resource_key, output amount,
                   input ready);
   modport sink   (input valid, input op, input resource_key, input amount,
                   output ready);
endinterface

`default_nettype wire

// ===== src/kab_rsp_if.sv =====
// Response channel of the keyed amount buffer: handshake plus one result.
// Depends on kab_pkg for the field types and widths.
`default_nettype none

interface kab_rsp_if import kab_pkg::*;;
   logic             valid;
   logic             ready;
   logic [AMT_W-1:0] moved_amount;
   logic             success;
   status_type       status;

   modport source (output valid, output moved_amount, output success, output status,
                   input ready);
   modport sink   (input valid, input moved_amount, input success, input status,
                   output ready);
endinterface

`default_nettype wire

// ===== src/kab_useq.sv =====
// Microcode sequencer: step counter, control store lookup and branch select.
// Depends on kab_pkg for the control word, action and condition types.
`default_nettype none

module kab_useq import kab_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire dp_flags_type flags,
   output act_type           act
);

   logic [PC_W-1:0] pc_ff, pc_in;
   uword_type       word;
   logic            cond_hit;

   assign word = ucode_rom(pc_ff);
   assign act  = word.act;

   always_comb begin
      unique case (word.cond)
         C_REQ_TAKEN:   cond_hit = flags.req_taken;
         C_SCAN_LAST:   cond_hit = flags.scan_last;
         C_TRIM_NEEDED: cond_hit = flags.trim_needed;
         C_TRIM_MORE:   cond_hit = flags.trim_more;
         C_OUT_FREE:    cond_hit = flags.out_free;
         default:       cond_hit = 1'b0;
      endcase
      pc_in = cond_hit ? word.tgt_true : word.tgt_false;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/kab_dpath.sv =====
// Datapath: slot table, scan and trim index, operation unit and response register.
// Depends on kab_pkg and both channel interfaces; driven by kab_useq actions.
`default_nettype none

module kab_dpath import kab_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   kab_req_if.sink       req_chan,
   kab_rsp_if.source     rsp_chan,
   input  wire act_type  act,
   output dp_flags_type  flags
);

   logic [KEY_BITS-1:0] slot_key_ff [SLOTS];
   logic [AMT_W-1:0]    slot_amt_ff [SLOTS];
   logic [SPAN_W-1:0]   span_ff, span_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   op_type              op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [REQ_AMT_W-1:0] amt_ff, amt_in;

   logic                hit_vld_ff, hit_vld_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [AMT_W-1:0]    hit_amt_ff, hit_amt_in;
   logic                free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;

   logic [AMT_W-1:0]    res_moved_ff, res_moved_in;
   logic                res_ok_ff, res_ok_in;
   status_type          res_st_ff, res_st_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [AMT_W-1:0]    rsp_moved_ff;
   logic                rsp_ok_ff;
   status_type          rsp_st_ff;

   logic [KEY_BITS-1:0] rd_key;
   logic [AMT_W-1:0]    rd_amt;
   logic                rd_free;
   logic                in_span;
   logic                scan_last;
   logic                out_free;
   logic                req_taken;

   logic [AMT_W-1:0]    amt_ext;
   logic [AMT_W-1:0]    room;
   logic [AMT_W-1:0]    add_mv;
   logic [AMT_W-1:0]    got;
   logic [AMT_W-1:0]    remain;
   logic [SPAN_W-1:0]   hit_end;
   logic [SPAN_W-1:0]   free_end;
   logic                ignore;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   logic [KEY_BITS-1:0] wr_key;
   logic [AMT_W-1:0]    wr_amt;
   logic [SPAN_W-1:0]   ex_span;
   logic                ex_cut;
   logic                trim_needed;

   // Single read port of the slot table, addressed by the walk index.
   assign rd_key    = slot_key_ff[idx_ff];
   assign rd_amt    = slot_amt_ff[idx_ff];
   assign rd_free   = (rd_key == '0) || (rd_amt == '0);
   assign in_span   = {1'b0, idx_ff} < span_ff;
   assign scan_last = idx_ff == IDX_W'(SLOTS - 1);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_taken = (act == ACT_FETCH) && req_chan.valid;

   assign amt_ext  = {{(AMT_W - REQ_AMT_W){1'b0}}, amt_ff};
   assign room     = AMT_MAX - hit_amt_ff;
   assign add_mv   = (amt_ext < room) ? amt_ext : room;
   assign got      = (amt_ext < hit_amt_ff) ? amt_ext : hit_amt_ff;
   assign remain   = hit_amt_ff - got;
   assign hit_end  = {1'b0, hit_idx_ff} + SPAN_W'(1);
   assign free_end = {1'b0, free_idx_ff} + SPAN_W'(1);
   assign ignore   = (key_ff == '0) || ((op_ff != OP_COUNT) && (amt_ff == '0));

   // Operation unit: works on the slot found by the scan and its latched amount.
   always_comb begin
      res_moved_in = '0;
      res_ok_in    = 1'b0;
      res_st_in    = ST_IGNORED;
      wr_en        = 1'b0;
      wr_idx       = hit_idx_ff;
      wr_key       = key_ff;
      wr_amt       = hit_amt_ff;
      ex_span      = span_ff;
      ex_cut       = 1'b0;
      if (ignore) begin
         res_st_in = ST_IGNORED;
      end else if (op_ff == OP_ADD) begin
         if (hit_vld_ff) begin
            res_moved_in = add_mv;
            res_ok_in    = 1'b1;
            res_st_in    = (add_mv < amt_ext) ? ST_SAT : ST_OK;
            wr_en        = 1'b1;
            wr_amt       = hit_amt_ff + add_mv;
         end else if (free_vld_ff) begin
            res_moved_in = amt_ext;
            res_ok_in    = 1'b1;
            res_st_in    = ST_OK;
            wr_en        = 1'b1;
            wr_idx       = free_idx_ff;
            wr_amt       = amt_ext;
            if (free_end > span_ff) begin
               ex_span = free_end;
            end
         end else begin
            res_st_in = ST_FULL;
         end
      end else if (!hit_vld_ff) begin
         res_st_in = ST_ABSENT;
      end else if (op_ff == OP_COUNT) begin
         res_moved_in = hit_amt_ff;
         res_ok_in    = 1'b1;
         res_st_in    = ST_OK;
      end else if ((op_ff == OP_TAKE) && (hit_amt_ff < amt_ext)) begin
         res_st_in = ST_SHORT;
      end else begin
         res_moved_in = got;
         res_ok_in    = 1'b1;
         res_st_in    = ST_OK;
         wr_en        = 1'b1;
         wr_amt       = remain;
         if (remain == '0) begin
            wr_key = '0;
            // Emptying the last slot of the span pulls the span back to it.
            if (hit_end == span_ff) begin
               ex_span = {1'b0, hit_idx_ff};
               ex_cut  = 1'b1;
            end
         end
      end
   end

   assign trim_needed = ex_cut && (hit_idx_ff != '0);

   always_comb begin
      span_in      = span_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      amt_in       = amt_ff;
      hit_vld_in   = hit_vld_ff;
      hit_idx_in   = hit_idx_ff;
      hit_amt_in   = hit_amt_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      unique case (act)
         ACT_FETCH: begin
            if (req_chan.valid) begin
               op_in       = req_chan.op;
               key_in      = req_chan.resource_key[KEY_BITS-1:0];
               amt_in      = req_chan.amount;
               idx_in      = '0;
               hit_vld_in  = 1'b0;
               free_vld_in = 1'b0;
            end
         end
         ACT_SCAN: begin
            if (!hit_vld_ff && in_span && (rd_key == key_ff) && (rd_amt != '0)) begin
               hit_vld_in = 1'b1;
               hit_idx_in = idx_ff;
               hit_amt_in = rd_amt;
            end
            if (!free_vld_ff && rd_free) begin
               free_vld_in = 1'b1;
               free_idx_in = idx_ff;
            end
            idx_in = scan_last ? '0 : idx_ff + IDX_W'(1);
         end
         ACT_EXEC: begin
            span_in = ex_span;
            if (ex_cut) begin
               idx_in = hit_idx_ff - IDX_W'(1);
            end
         end
         ACT_TRIM: begin
            // The walk index always sits on the last slot inside the span.
            if (rd_free) begin
               span_in = {1'b0, idx_ff};
               idx_in  = idx_ff - IDX_W'(1);
            end
         end
         ACT_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((act == ACT_EMIT) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_key_ff[i] <= '0;
            slot_amt_ff[i] <= '0;
         end
      end else begin
         span_ff      <= span_in;
         rsp_valid_ff <= rsp_valid_in;
         if ((act == ACT_EXEC) && wr_en) begin
            slot_key_ff[wr_idx] <= wr_key;
            slot_amt_ff[wr_idx] <= wr_amt;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      amt_ff      <= amt_in;
      hit_vld_ff  <= hit_vld_in;
      hit_idx_ff  <= hit_idx_in;
      hit_amt_ff  <= hit_amt_in;
      free_vld_ff <= free_vld_in;
      free_idx_ff <= free_idx_in;
      if (act == ACT_EXEC) begin
         res_moved_ff <= res_moved_in;
         res_ok_ff    <= res_ok_in;
         res_st_ff    <= res_st_in;
      end
      if ((act == ACT_EMIT) && out_free) begin
         rsp_moved_ff <= res_moved_ff;
         rsp_ok_ff    <= res_ok_ff;
         rsp_st_ff    <= res_st_ff;
      end
   end

   assign req_chan.ready        = act == ACT_FETCH;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.moved_amount = rsp_moved_ff;
   assign rsp_chan.success      = rsp_ok_ff;
   assign rsp_chan.status       = rsp_st_ff;

   assign flags.req_taken   = req_taken;
   assign flags.scan_last   = scan_last;
   assign flags.trim_needed = trim_needed;
   assign flags.trim_more   = rd_free && (idx_ff != '0);
   assign flags.out_free    = out_free;

   a_trim_at_span_end: assert property (@(posedge clock) disable iff (reset)
      (act == ACT_TRIM) |-> (span_ff == ({1'b0, idx_ff} + SPAN_W'(1))))
      else $error("trim index is not on the last slot of the span");

   a_hit_inside_span: assert property (@(posedge clock) disable iff (reset)
      ((act == ACT_EXEC) && hit_vld_ff) |-> ({1'b0, hit_idx_ff} < span_ff))
      else $error("matched slot lies outside the used span");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(act == ACT_EMIT))
      else $error("response raised outside the emit step");

   a_success_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ok_ff == ((rsp_st_ff == ST_OK) || (rsp_st_ff == ST_SAT))))
      else $error("success flag disagrees with status");

endmodule

`default_nettype wire

// ===== src/keyed_amount_buffer.sv =====
// Top level of the keyed amount buffer: microcode sequencer plus datapath.
// Depends on kab_pkg, kab_req_if, kab_rsp_if, kab_useq and kab_dpath.
//
//   channel    direction  handshake      payload
//   req_chan   in         valid/ready    op, resource_key, amount
//   rsp_chan   out        valid/ready    moved_amount, success, status
//
// A transaction accepts the request, scans every slot of the table through its
// single read port, executes, trims the used span back over empty slots when a
// remove or take empties the last slot of the span, and loads the response
// register.
// Reset clears the slot table and span directly; there is no clearing pass.
// A new request is accepted while the previous response still waits; the emit
// step waits while the response register is full and not being taken.
`default_nettype none

module keyed_amount_buffer import kab_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   kab_req_if.sink    req_chan,
   kab_rsp_if.source  rsp_chan
);

   act_type      act;
   dp_flags_type flags;

   kab_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .act   (act)
   );

   kab_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .act      (act),
      .flags    (flags)
   );

endmodule

`default_nettype wire
